[design/shared_exponent_quantizer_macros.svh]
// ----------------------------------------------------------------------------
// Shared exponent quantizer assertion macros
// Assertion wrappers used by the quantizer RTL; they expand to nothing when
// SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef SHARED_EXPONENT_QUANTIZER_MACROS_SVH
`define SHARED_EXPONENT_QUANTIZER_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication, disabled during reset.
`define SXQ_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("shared_exponent_quantizer: assertion failed");
// Next-cycle implication, disabled during reset.
`define SXQ_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("shared_exponent_quantizer: assertion failed");
`else
`define SXQ_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define SXQ_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif

`endif

[design/sxq_pkg.sv]
// ----------------------------------------------------------------------------
// Shared exponent quantizer package
// Types and fixed constants shared by the quantizer modules.
// ----------------------------------------------------------------------------
package sxq_pkg;

    localparam logic [23:0] SQRT2_MANT    = 24'hB504F3;
    localparam logic [23:0] INV_SQRT2_Q24 = 24'hB504F3;
    localparam logic [23:0] MANT_ONE      = 24'h800000;
    localparam logic [16:0] EXP_BIAS      = 17'd32767;
    localparam logic [16:0] CODE_SAT      = 17'd65536;
    localparam logic [17:0] CODE_MID      = 18'd32768;
    localparam logic [17:0] CODE_MAX      = 18'd65535;

    typedef enum logic [1:0] {
        STATUS_OK      = 2'd0,
        STATUS_BAD_MAX = 2'd1,
        STATUS_PARTIAL = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        FSM_IDLE,
        FSM_EXP,
        FSM_READ,
        FSM_MUL,
        FSM_CODE
    } fsm_t;

    // Scale of a group: S = 2^half, times sqrt2 when odd is set.
    typedef struct packed {
        logic signed [8:0] half;
        logic              odd;
    } scale_t;

    typedef struct packed {
        logic [15:0] word;
        scale_t      scale;
    } exp_info_t;

    typedef struct packed {
        logic [15:0] code;
        logic        is_exp;
        logic        last;
        status_t     status;
    } result_t;

endpackage

[design/sxq_ram.sv]
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module sxq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 24,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[design/sxq_exp.sv]
// ----------------------------------------------------------------------------
// Shared exponent unit
// Turns the group maximum into the exponent word and the scale used to
// divide each sample.
// ----------------------------------------------------------------------------
module sxq_exp (
    input  logic [30:0]          group_max,
    output sxq_pkg::exp_info_t   info
);

    import sxq_pkg::*;

    logic [7:0]        ex;
    logic [22:0]       frac;
    logic [4:0]        lead;
    logic [23:0]       nm;
    logic signed [9:0] e;
    logic [1:0]        d;
    logic [16:0]       wsum;

    always_comb
    begin
        ex   = group_max[30:23];
        frac = group_max[22:0];
        lead = '0;
        for (int i = 0; i < 23; i++)
        begin
            if (frac[i])
            begin
                lead = 5'(i);
            end
        end
        if (ex != 8'd0)
        begin
            nm = {1'b1, frac};
            e  = $signed({2'b00, ex}) - 10'sd127;
        end
        else
        begin
            // Subnormal: normalize so that the leading one sits at bit 23.
            nm = {1'b0, frac} << (5'd23 - lead);
            e  = $signed({5'b00000, lead}) - 10'sd149;
        end
        if (nm == MANT_ONE)
        begin
            d = 2'd0;
        end
        else if (nm <= SQRT2_MANT)
        begin
            d = 2'd1;
        end
        else
        begin
            d = 2'd2;
        end
        wsum = 17'($signed({e[9], e, 1'b0})) + {15'd0, d} + EXP_BIAS;
        info.word       = wsum[15:0];
        info.scale.odd  = (d == 2'd1);
        info.scale.half = (d == 2'd2) ? 9'(e + 10'sd1) : 9'(e);
    end

endmodule

[design/sxq_quant.sv]
// ----------------------------------------------------------------------------
// Sample quantizer
// Two-step datapath: a registered mantissa multiply by 1/sqrt2 when the
// scale is odd, then the shift, rounding and clamp that form the 16-bit code.
// ----------------------------------------------------------------------------
module sxq_quant (
    input  logic            clk,
    input  logic            load,
    input  logic [31:0]     sample,
    input  sxq_pkg::scale_t scale,
    output logic [15:0]     code
);

    import sxq_pkg::*;

    logic [7:0]         ex;
    logic [7:0]         exe;
    logic [23:0]        mant;
    logic [47:0]        prod_next;
    logic signed [10:0] sh_next;

    logic [47:0]        prod_reg;
    logic signed [10:0] sh_reg;
    logic               neg_reg;
    logic               zero_reg;

    logic [10:0]        nshift;
    logic [63:0]        shl;
    logic [47:0]        shr;
    logic [47:0]        mask;
    logic [16:0]        ip;
    logic               fr;
    logic [17:0]        dsum;
    logic [17:0]        psum;

    always_comb
    begin
        ex   = sample[30:23];
        mant = (ex != 8'd0) ? {1'b1, sample[22:0]} : {1'b0, sample[22:0]};
        exe  = (ex != 8'd0) ? ex : 8'd1;
        if (scale.odd)
        begin
            prod_next = {24'd0, mant} * {24'd0, INV_SQRT2_Q24};
        end
        else
        begin
            prod_next = {24'd0, mant};
        end
        sh_next = $signed({3'b000, exe}) - 11'sd135 - (scale.odd ? 11'sd24 : 11'sd0)
                  - $signed({{2{scale.half[8]}}, scale.half});
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            prod_reg <= prod_next;
            sh_reg   <= sh_next;
            neg_reg  <= sample[31];
            zero_reg <= (sample[30:0] == 31'd0);
        end
    end

    always_comb
    begin
        nshift = 11'(-sh_reg);
        shl    = {16'd0, prod_reg} << sh_reg[4:0];
        shr    = prod_reg >> nshift[5:0];
        mask   = ~({48{1'b1}} << nshift[5:0]);
        ip     = '0;
        fr     = 1'b0;
        if (sh_reg >= 11'sd0)
        begin
            if (sh_reg > 11'sd16 || shl > 64'(CODE_SAT))
            begin
                ip = CODE_SAT;
            end
            else
            begin
                ip = shl[16:0];
            end
        end
        else if (nshift >= 11'd48)
        begin
            ip = '0;
            fr = (prod_reg != 48'd0);
        end
        else
        begin
            ip = (shr > 48'(CODE_SAT)) ? CODE_SAT : shr[16:0];
            fr = |(prod_reg & mask);
        end
        // Negative samples take the ceiling of the scaled magnitude.
        dsum = {1'b0, ip} + {17'd0, fr};
        psum = {1'b0, ip} + CODE_MID;
        if (zero_reg)
        begin
            code = CODE_MID[15:0];
        end
        else if (neg_reg)
        begin
            code = (dsum >= CODE_MID) ? 16'd0 : 16'(CODE_MID - dsum);
        end
        else
        begin
            code = (psum > CODE_MAX) ? CODE_MAX[15:0] : psum[15:0];
        end
    end

endmodule

[design/shared_exponent_quantizer.sv]
// ----------------------------------------------------------------------------
// Shared exponent quantizer
// Block floating point encoder: float samples in, one exponent word and
// one 16-bit code per sample out for each group with a finite nonzero maximum.
// ----------------------------------------------------------------------------
// Samples are taken one per cycle while the block is collecting a group and
// the output is free, and are written into the sample RAM. When the group
// completes, the block stops taking requests and emits the exponent word
// and then one code per sample, each formed by a RAM read, a mantissa
// multiply and then the shift and round. A group whose maximum is zero,
// infinite or NaN, or a block that ends mid-group, produces a single status
// result in the cycle after its last sample. Writing group_size drops any
// partial group.
`include "shared_exponent_quantizer_macros.svh"

module shared_exponent_quantizer #(
    parameter int MAX_GROUP = 24
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        group_size_we,
    input  logic [4:0]  group_size,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [31:0] sample_bits,
    input  logic        end_of_block,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [15:0] code_word,
    output logic        is_exponent,
    output logic        last_of_group,
    output logic [1:0]  status
);

    import sxq_pkg::*;

    localparam int CW = $clog2(MAX_GROUP + 1);
    localparam int AW = (MAX_GROUP > 1) ? $clog2(MAX_GROUP) : 1;
    localparam int SW = (CW > 5) ? CW : 5;
    localparam logic [SW-1:0] MAX_SW = SW'(MAX_GROUP);

    fsm_t          state_reg;
    fsm_t          state_next;
    logic [4:0]    size_reg;
    logic [CW-1:0] fill_reg;
    logic [30:0]   max_reg;
    logic [AW-1:0] idx_reg;
    scale_t        scale_reg;
    result_t       out_reg;
    logic          out_valid_reg;

    logic [SW-1:0] size_ext;
    logic [CW-1:0] size_eff;
    logic [CW-1:0] fill_inc;
    logic [30:0]   cand_max;
    logic          complete;
    logic          bad_max;
    logic          out_free;
    logic          accept;
    logic          idx_last;

    logic          load_res;
    result_t       res_next;
    logic          capture_scale;
    logic          clear_group;
    logic          idx_step;
    logic          rd_en;
    logic          quant_load;

    exp_info_t     exp_info;
    logic [31:0]   rd_data;
    logic [15:0]   quant_code;

    // Out-of-range sizes: zero acts as one, large values as the store depth.
    always_comb
    begin
        size_ext = SW'(size_reg);
        if (size_ext == '0)
        begin
            size_eff = CW'(1);
        end
        else if (size_ext > MAX_SW)
        begin
            size_eff = CW'(MAX_GROUP);
        end
        else
        begin
            size_eff = CW'(size_ext);
        end
    end

    assign out_free = !out_valid_reg || out_ready;
    assign in_ready = (state_reg == FSM_IDLE) && out_free && !group_size_we;
    assign accept   = in_valid && in_ready;
    assign fill_inc = fill_reg + CW'(1);
    assign complete = (fill_inc >= size_eff);
    assign cand_max = (sample_bits[30:0] > max_reg) ? sample_bits[30:0] : max_reg;
    assign bad_max  = (cand_max == 31'd0) || (cand_max[30:23] == 8'hFF);
    assign idx_last = ((CW'(idx_reg) + CW'(1)) == fill_reg);

    sxq_ram #(
        .WIDTH (32),
        .DEPTH (MAX_GROUP),
        .AW    (AW)
    ) u_store (
        .clk   (clk),
        .we    (accept),
        .waddr (fill_reg[AW-1:0]),
        .wdata (sample_bits),
        .re    (rd_en),
        .raddr (idx_reg),
        .rdata (rd_data)
    );

    sxq_exp u_exp (
        .group_max (max_reg),
        .info      (exp_info)
    );

    sxq_quant u_quant (
        .clk    (clk),
        .load   (quant_load),
        .sample (rd_data),
        .scale  (scale_reg),
        .code   (quant_code)
    );

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            FSM_IDLE:
            begin
                if (accept && complete && !bad_max)
                begin
                    state_next = FSM_EXP;
                end
            end
            FSM_EXP:
            begin
                if (out_free)
                begin
                    state_next = FSM_READ;
                end
            end
            FSM_READ:
            begin
                state_next = FSM_MUL;
            end
            FSM_MUL:
            begin
                state_next = FSM_CODE;
            end
            FSM_CODE:
            begin
                if (out_free)
                begin
                    state_next = idx_last ? FSM_IDLE : FSM_READ;
                end
            end
            default:
            begin
                state_next = FSM_IDLE;
            end
        endcase
    end

    always_comb
    begin
        load_res      = 1'b0;
        res_next      = '{code: 16'd0, is_exp: 1'b0, last: 1'b1, status: STATUS_OK};
        capture_scale = 1'b0;
        clear_group   = 1'b0;
        idx_step      = 1'b0;
        rd_en         = 1'b0;
        quant_load    = 1'b0;
        case (state_reg)
            FSM_IDLE:
            begin
                if (accept && !complete && end_of_block)
                begin
                    load_res        = 1'b1;
                    res_next.status = STATUS_PARTIAL;
                end
                else if (accept && complete && bad_max)
                begin
                    load_res        = 1'b1;
                    res_next.status = STATUS_BAD_MAX;
                end
            end
            FSM_EXP:
            begin
                if (out_free)
                begin
                    load_res        = 1'b1;
                    res_next.code   = exp_info.word;
                    res_next.is_exp = 1'b1;
                    res_next.last   = 1'b0;
                    capture_scale   = 1'b1;
                end
            end
            FSM_READ:
            begin
                rd_en = 1'b1;
            end
            FSM_MUL:
            begin
                quant_load = 1'b1;
            end
            FSM_CODE:
            begin
                if (out_free)
                begin
                    load_res      = 1'b1;
                    res_next.code = quant_code;
                    res_next.last = idx_last;
                    idx_step      = 1'b1;
                    clear_group   = idx_last;
                end
            end
            default:
            begin
                load_res = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= FSM_IDLE;
            size_reg      <= 5'd24;
            fill_reg      <= '0;
            max_reg       <= '0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (group_size_we)
            begin
                size_reg <= group_size;
            end
            if (group_size_we && state_reg == FSM_IDLE)
            begin
                fill_reg <= '0;
                max_reg  <= '0;
            end
            else if (accept)
            begin
                if ((complete && bad_max) || (!complete && end_of_block))
                begin
                    fill_reg <= '0;
                    max_reg  <= '0;
                end
                else
                begin
                    // A complete group keeps its count as the bound of the code loop.
                    fill_reg <= fill_inc;
                    max_reg  <= cand_max;
                end
            end
            else if (clear_group)
            begin
                fill_reg <= '0;
                max_reg  <= '0;
            end
            if (capture_scale)
            begin
                idx_reg <= '0;
            end
            else if (idx_step)
            begin
                idx_reg <= idx_reg + AW'(1);
            end
            if (load_res)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (capture_scale)
        begin
            scale_reg <= exp_info.scale;
        end
        if (load_res)
        begin
            out_reg <= res_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign code_word     = out_reg.code;
    assign is_exponent   = out_reg.is_exp;
    assign last_of_group = out_reg.last;
    assign status        = out_reg.status;

    `SXQ_ASSERT_NXT(a_bad_max_result, clk, rst_n, accept && complete && bad_max, out_valid_reg && out_reg.last && out_reg.status == STATUS_BAD_MAX)
    `SXQ_ASSERT_IMP(a_exp_group_nonempty, clk, rst_n, state_reg == FSM_EXP, fill_reg != '0)
    `SXQ_ASSERT_IMP(a_code_index_bound, clk, rst_n, state_reg == FSM_CODE, CW'(idx_reg) < fill_reg)
    `SXQ_ASSERT_IMP(a_exp_word_ok, clk, rst_n, out_valid_reg && out_reg.is_exp, out_reg.status == STATUS_OK && !out_reg.last)
    `SXQ_ASSERT_IMP(a_idle_fill_bound, clk, rst_n, state_reg == FSM_IDLE, fill_reg < size_eff)

endmodule

[test/testbench.sv]
// ----------------------------------------------------------------------------
// Shared exponent quantizer testbench
// Drives float samples into the quantizer in bursts while the receiver
// stalls on its own pattern, and checks every exponent word, sample code and
// status result against a bit-exact prediction kept by a scoreboard class.
// ----------------------------------------------------------------------------
module testbench;
    import sxq_pkg::*;

    localparam int MAX_GROUP = 24;

    class quant_scoreboard;
        logic [31:0] sample_mem [MAX_GROUP];
        int unsigned fill;
        logic [30:0] peak_mag;
        logic [4:0]  size_reg;
        result_t     expected_results [$];
        int unsigned errors;

        function new();
            fill = 0;
            peak_mag = '0;
            size_reg = 5'd24;
            errors = 0;
        endfunction

        function int unsigned group_len();
            if (size_reg == 5'd0)
                return 1;
            if (size_reg > MAX_GROUP)
                return MAX_GROUP;
            return size_reg;
        endfunction

        function int unsigned pending();
            return expected_results.size();
        endfunction

        function void configure(logic [4:0] value);
            size_reg = value;
            fill = 0;
            peak_mag = '0;
        endfunction

        function void expect_result(logic [15:0] code, logic is_exp, logic last,
                                    status_t st);
            result_t r;
            r.code = code;
            r.is_exp = is_exp;
            r.last = last;
            r.status = st;
            expected_results.push_back(r);
        endfunction

        // Code of one sample for scale S = 2^half, times sqrt2 when odd is set.
        function logic [15:0] sample_code(logic [31:0] bits, int half, bit odd);
            logic [7:0]  ex;
            logic [23:0] mant;
            logic [63:0] prod;
            logic [63:0] ip;
            logic [63:0] dsum;
            int          exe;
            int          sh;
            int          n;
            bit          frac_lost;
            if (bits[30:0] == 31'd0)
                return 16'h8000;
            ex = bits[30:23];
            mant = (ex != 8'd0) ? {1'b1, bits[22:0]} : {1'b0, bits[22:0]};
            exe = (ex != 8'd0) ? int'(ex) : 1;
            prod = odd ? 64'(mant) * 64'(INV_SQRT2_Q24) : 64'(mant);
            sh = exe - 150 - (odd ? 24 : 0) - half + 15;
            frac_lost = 1'b0;
            if (sh >= 0)
            begin
                ip = (sh > 16) ? 64'd65536 : (prod << sh);
            end
            else
            begin
                n = -sh;
                if (n >= 64)
                begin
                    ip = '0;
                    frac_lost = 1'b1;
                end
                else
                begin
                    ip = prod >> n;
                    frac_lost = (prod & ((64'd1 << n) - 64'd1)) != 64'd0;
                end
            end
            if (ip > 64'd65536)
                ip = 64'd65536;
            // Negative samples take the floor of the negated value.
            if (bits[31])
            begin
                dsum = ip + 64'(frac_lost);
                return (dsum >= 64'd32768) ? 16'd0 : 16'(64'd32768 - dsum);
            end
            ip = ip + 64'd32768;
            return (ip > 64'd65535) ? 16'hFFFF : ip[15:0];
        endfunction

        function void note_request(logic [31:0] bits, logic eob);
            int unsigned size;
            logic [23:0] nm;
            logic [22:0] frac;
            int          e;
            int          d;
            int          p;
            int          half;
            bit          odd;
            size = group_len();
            if (fill < MAX_GROUP)
                sample_mem[fill] = bits;
            fill++;
            if (bits[30:0] > peak_mag)
                peak_mag = bits[30:0];
            if (fill < size)
            begin
                if (eob)
                begin
                    expect_result(16'd0, 1'b0, 1'b1, STATUS_PARTIAL);
                    fill = 0;
                    peak_mag = '0;
                end
                return;
            end
            if (peak_mag == 31'd0 || peak_mag[30:23] == 8'hFF)
            begin
                expect_result(16'd0, 1'b0, 1'b1, STATUS_BAD_MAX);
                fill = 0;
                peak_mag = '0;
                return;
            end
            frac = peak_mag[22:0];
            if (peak_mag[30:23] != 8'd0)
            begin
                nm = {1'b1, frac};
                e = int'(peak_mag[30:23]) - 127;
            end
            else
            begin
                // Subnormal maximum: normalize on its leading one.
                p = 22;
                while (p > 0 && !frac[p])
                    p--;
                nm = {1'b0, frac} << (23 - p);
                e = p - 149;
            end
            d = (nm == MANT_ONE) ? 0 : ((nm <= SQRT2_MANT) ? 1 : 2);
            odd = (d == 1);
            half = (d == 2) ? e + 1 : e;
            expect_result(16'(2 * e + d + int'(EXP_BIAS)), 1'b1, 1'b0, STATUS_OK);
            for (int i = 0; i < fill && i < MAX_GROUP; i++)
                expect_result(sample_code(sample_mem[i], half, odd), 1'b0,
                              (i + 1 == fill), STATUS_OK);
            fill = 0;
            peak_mag = '0;
        endfunction

        function void check_result(logic [15:0] code, logic is_exp, logic last,
                                   logic [1:0] st);
            result_t want;
            if (expected_results.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("unexpected result: code %h exp %b last %b status %0d",
                             code, is_exp, last, st);
                return;
            end
            want = expected_results.pop_front();
            if (want.code !== code || want.is_exp !== is_exp || want.last !== last ||
                want.status !== status_t'(st))
            begin
                errors++;
                if (errors <= 10)
                    $display({"mismatch: expected code %h exp %b last %b status %0d,",
                              " got code %h exp %b last %b status %0d"},
                             want.code, want.is_exp, want.last, want.status,
                             code, is_exp, last, st);
            end
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        group_size_we = 1'b0;
    logic [4:0]  group_size = 5'd0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [31:0] sample_bits = 32'd0;
    logic        end_of_block = 1'b0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [15:0] code_word;
    logic        is_exponent;
    logic        last_of_group;
    logic [1:0]  status;

    logic [7:0]  stall_phase = 8'd0;
    logic [1:0]  ready_mode = 2'd0;
    int          burst_left = 0;
    quant_scoreboard sb;

    // Directed requests, end_of_block in bit 32, run with a group size of 4.
    logic [32:0] directed_items [26] = '{
        {1'b0, 32'h7F7FFFFF}, {1'b0, 32'hFF7FFFFF}, {1'b0, 32'h00000001},
        {1'b0, 32'h80000000},
        {1'b0, 32'h00000000}, {1'b0, 32'h80000000}, {1'b0, 32'h00000000},
        {1'b0, 32'h80000000},
        {1'b0, 32'h3F800000}, {1'b0, 32'h7F800000}, {1'b0, 32'h3F000000},
        {1'b0, 32'hBF800000},
        {1'b0, 32'h40490FDB}, {1'b1, 32'hBFB504F3},
        {1'b0, 32'h3FB504F3}, {1'b0, 32'hBF3504F3}, {1'b0, 32'h00400000},
        {1'b1, 32'h3F800000},
        {1'b0, 32'h3FB504F4}, {1'b0, 32'hBFB504F4}, {1'b0, 32'h00000003},
        {1'b0, 32'h80000001},
        {1'b0, 32'h3F800000}, {1'b0, 32'hBF800000}, {1'b0, 32'h3E800000},
        {1'b0, 32'hFFFFFFFF}
    };

    shared_exponent_quantizer #(
        .MAX_GROUP(MAX_GROUP)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .group_size_we(group_size_we),
        .group_size(group_size),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .sample_bits(sample_bits),
        .end_of_block(end_of_block),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .code_word(code_word),
        .is_exponent(is_exponent),
        .last_of_group(last_of_group),
        .status(status)
    );

    always #5 clk = ~clk;

    // The receiver switches between always ready, random stalls and a fixed
    // duty pattern whenever its 8-bit phase counter wraps.
    always @(posedge clk)
    begin
        stall_phase <= stall_phase + 8'd1;
        if (stall_phase == 8'd0)
            ready_mode <= 2'($urandom_range(0, 3));
        case (ready_mode)
            2'd0: out_ready <= 1'b1;
            2'd1: out_ready <= ($urandom_range(0, 3) != 0);
            2'd2: out_ready <= (stall_phase[2:0] < 3'd3);
            default: out_ready <= ($urandom_range(0, 1) != 0);
        endcase
    end

    always @(posedge clk)
    begin
        if (rst_n && in_valid && in_ready)
            sb.note_request(sample_bits, end_of_block);
        if (rst_n && out_valid && out_ready)
            sb.check_result(code_word, is_exponent, last_of_group, status);
    end

    function automatic logic [31:0] random_sample();
        int unsigned sel;
        logic        sign;
        logic [22:0] frac;
        sel = $urandom_range(0, 99);
        sign = 1'($urandom);
        frac = 23'($urandom);
        if (sel < 60)
            return {sign, 8'($urandom_range(120, 134)), frac};
        if (sel < 70)
            return $urandom;
        if (sel < 80)
            return {sign, 8'd0, frac};
        if (sel < 88)
            return {sign, 31'd0};
        if (sel < 92)
            return {sign, 8'($urandom_range(200, 254)), frac};
        if (sel < 96)
        begin
            case ($urandom_range(0, 3))
                0: frac = 23'd0;
                1: frac = SQRT2_MANT[22:0];
                2: frac = SQRT2_MANT[22:0] + 23'd1;
                default: frac = SQRT2_MANT[22:0] - 23'd1;
            endcase
            return {sign, 8'($urandom_range(100, 150)), frac};
        end
        if (sel < 97)
            return {sign, 8'hFF, ($urandom_range(0, 1) != 0) ? 23'd0 : frac};
        return {sign, 8'($urandom_range(1, 10)), frac};
    endfunction

    task automatic push_sample(input logic [31:0] bits, input logic eob);
        sample_bits <= bits;
        end_of_block <= eob;
        in_valid <= 1'b1;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        if (burst_left > 0)
        begin
            burst_left--;
        end
        else
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 12))
                @(posedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                    : $urandom_range(0, 8);
        end
    endtask

    // Holds the sender until every predicted result has arrived, then lets
    // the block settle so that it is idle for a group_size write.
    task automatic drain_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (30)
            @(posedge clk);
    endtask

    task automatic write_group_size(input logic [4:0] value);
        group_size_we <= 1'b1;
        group_size <= value;
        @(posedge clk);
        sb.configure(value);
        group_size_we <= 1'b0;
    endtask

    initial
    begin
        #2000000;
        $display("*** FAILED ***");
        $finish;
    end

    initial
    begin
        logic [4:0]  gs;
        int unsigned len;
        int unsigned pos;
        int unsigned n_items;
        logic        eob;
        logic        zero_grp;
        logic [31:0] bits;
        sb = new();
        repeat (10)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // One full group at the reset group size.
        for (int k = 0; k < 24; k++)
            push_sample(random_sample(), (k == 23) && ($urandom_range(0, 1) != 0));
        drain_results();

        write_group_size(5'd4);
        for (int k = 0; k < 26; k++)
            push_sample(directed_items[k][31:0], directed_items[k][32]);
        drain_results();

        zero_grp = 1'b0;
        for (int ph = 0; ph < 9; ph++)
        begin
            case (ph)
                0: gs = 5'd1;
                1: gs = 5'd0;
                2: gs = 5'd31;
                3: gs = 5'd24;
                8: gs = 5'd2;
                default: gs = 5'($urandom_range(3, 23));
            endcase
            write_group_size(gs);
            len = sb.group_len();
            n_items = (len >= MAX_GROUP) ? 30 : 25;
            pos = 0;
            for (int k = 0; k < n_items; k++)
            begin
                if (pos == 0)
                    zero_grp = ($urandom_range(0, 24) == 0);
                bits = zero_grp ? {1'($urandom), 31'd0} : random_sample();
                if (pos + 1 == len)
                    eob = ($urandom_range(0, 4) == 0);
                else
                    eob = ($urandom_range(0, 39) == 0);
                push_sample(bits, eob);
                pos = (eob || pos + 1 == len) ? 0 : pos + 1;
            end
            drain_results();
        end

        if (sb.errors == 0 && sb.pending() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
